>>> rtl/tap_hold_key_resolver_unit_macros.svh
// assertion macros for the tap/hold key resolver
// expects clk and rst_n in the scope of each use
`ifndef TAP_HOLD_KEY_RESOLVER_UNIT_MACROS_SVH
`define TAP_HOLD_KEY_RESOLVER_UNIT_MACROS_SVH

// same-cycle implication, disabled during reset
`define THKR_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled during reset
`define THKR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/thkr_pkg.sv
// shared types and constants of the tap/hold key resolver
// no dependencies
package thkr_pkg;

    localparam int TIME_BITS   = 32;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 16;
    localparam int ACTION_W    = 3;
    localparam int NOW_W       = 32;
    localparam int S_TDATA_W   = 40;
    localparam int S_TUSER_W   = 3;
    localparam int M_TDATA_W   = 32;

    typedef logic [TIME_BITS-1:0] time_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_HOLD_TERM         = 3'd0,
        CFG_QUICK_TAP_WINDOW  = 3'd1,
        CFG_PRIOR_IDLE_WINDOW = 3'd2,
        CFG_MODE_FLAGS        = 3'd3,
        CFG_TAP_CODE          = 3'd4,
        CFG_HOLD_CODE         = 3'd5,
        CFG_DOUBLE_TAP_CODE   = 3'd6,
        CFG_KEY_POSITION      = 3'd7
    } cfg_idx_t;

    typedef enum logic [ACTION_W-1:0] {
        ACT_PRESS   = 3'd0,
        ACT_RELEASE = 3'd1,
        ACT_TICK    = 3'd2,
        ACT_NOTE    = 3'd3,
        ACT_CLEAR   = 3'd4
    } action_t;

    typedef enum logic [1:0] {
        K_NONE    = 2'd0,
        K_PRESS   = 2'd1,
        K_RELEASE = 2'd2,
        K_TAP     = 2'd3
    } kind_t;

    typedef enum logic [4:0] {
        ST_NONE   = 5'b00001,
        ST_TAP    = 5'b00010,
        ST_HOLD   = 5'b00100,
        ST_QUICK  = 5'b01000,
        ST_DTWAIT = 5'b10000
    } stage_t;

    localparam int MODE_RETRO = 2;
    localparam int MODE_HWU   = 3;

    localparam logic [1:0] FLAVOR_HOLD     = 2'd0;
    localparam logic [1:0] FLAVOR_BALANCED = 2'd1;
    localparam logic [1:0] FLAVOR_TAP      = 2'd2;
    localparam logic [1:0] FLAVOR_TUI      = 2'd3;

    typedef struct packed {
        logic [15:0] hold_term;
        logic [15:0] quick_tap_window;
        logic [15:0] prior_idle_window;
        logic [3:0]  mode_flags;
        logic [7:0]  tap_code;
        logic [7:0]  hold_code;
        logic [7:0]  double_tap_code;
        logic [7:0]  key_position;
    } cfg_t;

    typedef struct packed {
        action_t action;
        time_t   now;
        logic    other_pressed;
        logic    other_released;
    } evt_t;

    typedef struct packed {
        stage_t stage;
        time_t  stage_start;
        logic   was_interrupted;
        logic   other_was_released;
        time_t  last_tap_time;
        time_t  last_other_key_time;
    } key_state_t;

    typedef struct packed {
        kind_t      first_kind;
        logic [7:0] first_code;
        kind_t      second_kind;
        logic [7:0] second_code;
        logic       undecided;
    } res_t;

    // register defaults: hold term of 200 ms, everything else zero
    localparam cfg_t CFG_RESET = {16'd200, 16'd0, 16'd0, 4'd0, 8'd0, 8'd0, 8'd0, 8'd0};

    // idle key with cleared times and flags
    localparam key_state_t KEY_STATE_RESET = {ST_NONE, {TIME_BITS{1'b0}}, 1'b0, 1'b0,
                                              {TIME_BITS{1'b0}}, {TIME_BITS{1'b0}}};

endpackage

>>> rtl/thkr_cfg_regs.sv
// configuration register bank of the tap/hold key resolver
// depends on thkr_pkg
module thkr_cfg_regs (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [thkr_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [thkr_pkg::CFG_DATA_W-1:0] cfg_data,
    output thkr_pkg::cfg_t                cfg
);
    import thkr_pkg::*;

    cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= CFG_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_idx_t'(cfg_index))
                CFG_HOLD_TERM:         cfg_reg.hold_term         <= cfg_data;
                CFG_QUICK_TAP_WINDOW:  cfg_reg.quick_tap_window  <= cfg_data;
                CFG_PRIOR_IDLE_WINDOW: cfg_reg.prior_idle_window <= cfg_data;
                CFG_MODE_FLAGS:        cfg_reg.mode_flags        <= cfg_data[3:0];
                CFG_TAP_CODE:          cfg_reg.tap_code          <= cfg_data[7:0];
                CFG_HOLD_CODE:         cfg_reg.hold_code         <= cfg_data[7:0];
                CFG_DOUBLE_TAP_CODE:   cfg_reg.double_tap_code   <= cfg_data[7:0];
                CFG_KEY_POSITION:      cfg_reg.key_position      <= cfg_data[7:0];
                default:               cfg_reg                   <= cfg_reg;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

>>> rtl/thkr_resolve.sv
// single-pass decision logic: next key state and actions for one event
// depends on thkr_pkg
module thkr_resolve (
    input  thkr_pkg::cfg_t       cfg,
    input  thkr_pkg::key_state_t st,
    input  thkr_pkg::evt_t       evt,
    output thkr_pkg::key_state_t st_next,
    output thkr_pkg::res_t       res
);
    import thkr_pkg::*;

    logic  has_dt;
    logic  retro;
    logic  hwu;
    logic  [1:0] flavor;
    time_t el_start;
    time_t el_tap;
    time_t el_other;
    logic  expired;
    logic  win_done;
    logic  wi_n;
    logic  owr_n;
    logic  hold;
    logic  tap_after;

    assign has_dt   = (cfg.double_tap_code != 8'd0);
    assign retro    = cfg.mode_flags[MODE_RETRO];
    assign hwu      = cfg.mode_flags[MODE_HWU];
    assign flavor   = cfg.mode_flags[1:0];
    assign el_start = evt.now - st.stage_start;
    assign el_tap   = evt.now - st.last_tap_time;
    assign el_other = evt.now - st.last_other_key_time;
    assign expired  = (el_start >= TIME_BITS'(cfg.hold_term));
    assign win_done = (cfg.quick_tap_window != 16'd0)
                    ? (el_start >= TIME_BITS'(cfg.quick_tap_window)) : expired;
    assign wi_n     = st.was_interrupted | evt.other_pressed;
    assign owr_n    = st.other_was_released | evt.other_released;

    always_comb
    begin
        case (flavor)
            FLAVOR_HOLD:     hold = expired | evt.other_pressed;
            FLAVOR_BALANCED: hold = expired | (wi_n & owr_n);
            FLAVOR_TAP:      hold = expired;
            default:         hold = wi_n & ~expired;
        endcase
    end

    always_comb
    begin
        st_next         = st;
        res             = '0;
        res.first_kind  = K_NONE;
        res.second_kind = K_NONE;
        tap_after       = 1'b0;
        case (evt.action)
            ACT_PRESS:
            begin
                if (st.stage == ST_DTWAIT)
                begin
                    res.first_kind = K_TAP;
                    res.first_code = cfg.double_tap_code;
                    st_next.stage  = ST_QUICK;
                end
                else if (cfg.prior_idle_window != 16'd0 &&
                         el_other < TIME_BITS'(cfg.prior_idle_window))
                begin
                    res.first_kind = K_TAP;
                    res.first_code = cfg.tap_code;
                    st_next.stage  = ST_NONE;
                end
                else if (!has_dt && cfg.quick_tap_window != 16'd0 &&
                         el_tap < TIME_BITS'(cfg.quick_tap_window))
                begin
                    res.first_kind = K_PRESS;
                    res.first_code = cfg.tap_code;
                    st_next.stage  = ST_QUICK;
                end
                else
                begin
                    st_next.stage_start        = evt.now;
                    st_next.stage              = ST_TAP;
                    st_next.was_interrupted    = 1'b0;
                    st_next.other_was_released = 1'b0;
                    if (hwu)
                    begin
                        res.first_kind = K_PRESS;
                        res.first_code = cfg.hold_code;
                    end
                end
            end
            ACT_RELEASE:
            begin
                st_next.stage = ST_NONE;
                case (st.stage)
                    ST_TAP:
                    begin
                        if (hwu)
                        begin
                            res.first_kind = K_RELEASE;
                            res.first_code = cfg.hold_code;
                        end
                        if (retro && !st.was_interrupted && expired)
                        begin
                            tap_after             = 1'b1;
                            st_next.last_tap_time = evt.now;
                        end
                        else if (!retro || !expired)
                        begin
                            st_next.last_tap_time = evt.now;
                            if (has_dt)
                            begin
                                st_next.stage       = ST_DTWAIT;
                                st_next.stage_start = evt.now;
                            end
                            else
                            begin
                                tap_after = 1'b1;
                            end
                        end
                    end
                    ST_HOLD:
                    begin
                        res.first_kind = K_RELEASE;
                        res.first_code = cfg.hold_code;
                    end
                    ST_QUICK:
                    begin
                        res.first_kind        = K_RELEASE;
                        res.first_code        = has_dt ? cfg.double_tap_code : cfg.tap_code;
                        st_next.last_tap_time = evt.now;
                    end
                    default:
                    begin
                        st_next.stage = ST_NONE;
                    end
                endcase
            end
            ACT_TICK:
            begin
                st_next.was_interrupted    = wi_n;
                st_next.other_was_released = owr_n;
                if (st.stage == ST_DTWAIT)
                begin
                    if (win_done)
                    begin
                        res.first_kind = K_TAP;
                        res.first_code = cfg.tap_code;
                        st_next.stage  = ST_NONE;
                    end
                end
                else if (st.stage == ST_TAP)
                begin
                    if (hold)
                    begin
                        if (!hwu)
                        begin
                            res.first_kind = K_PRESS;
                            res.first_code = cfg.hold_code;
                        end
                        st_next.stage = ST_HOLD;
                    end
                    else if (flavor == FLAVOR_TUI && expired && !wi_n)
                    begin
                        if (hwu)
                        begin
                            res.first_kind = K_RELEASE;
                            res.first_code = cfg.hold_code;
                        end
                        tap_after             = 1'b1;
                        st_next.last_tap_time = evt.now;
                        st_next.stage         = ST_NONE;
                    end
                end
            end
            ACT_NOTE:
            begin
                st_next.last_other_key_time = evt.now;
            end
            ACT_CLEAR:
            begin
                st_next.last_tap_time       = '0;
                st_next.last_other_key_time = '0;
            end
            default:
            begin
                st_next = st;
            end
        endcase
        // tap follows the hold release in the second slot when one was sent
        if (tap_after)
        begin
            if (hwu)
            begin
                res.second_kind = K_TAP;
                res.second_code = cfg.tap_code;
            end
            else
            begin
                res.first_kind = K_TAP;
                res.first_code = cfg.tap_code;
            end
        end
        res.undecided = (st_next.stage == ST_TAP);
    end

endmodule

>>> rtl/tap_hold_key_resolver_unit.sv
// top level of the tap/hold key resolver: input register, key state, result register
// depends on thkr_pkg, thkr_cfg_regs, thkr_resolve, tap_hold_key_resolver_unit_macros.svh
//
//  channel  | direction | handshake           | content
//  s_*      | in        | s_tvalid / s_tready | event: time, other-key flags, action
//  m_*      | out       | m_tvalid / m_tready | two key actions, key position, undecided
//  cfg_*    | in        | cfg_we              | register index and data
//
// one event per cycle while the result is not stalled; each event passes from s to m
// through the input register and the result register around the decision logic
// an event is resolved as it leaves the input register, updating the key state
// a stalled result holds the input register; s_tready falls only when both are full
// reset returns the config registers to defaults and the key to the idle stage
module tap_hold_key_resolver_unit (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [thkr_pkg::S_TDATA_W-1:0]  s_tdata,  // now[31:0], other_pressed, other_released
    input  logic [thkr_pkg::S_TUSER_W-1:0]  s_tuser,  // action
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // first_kind, first_code, second_kind, second_code, reported_key, undecided
    output logic [thkr_pkg::M_TDATA_W-1:0]  m_tdata,
    input  logic                            cfg_we,
    input  logic [thkr_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [thkr_pkg::CFG_DATA_W-1:0] cfg_data
);
    import thkr_pkg::*;

`include "tap_hold_key_resolver_unit_macros.svh"

    cfg_t       cfg;
    evt_t       evt_reg;
    evt_t       evt_next;
    logic       in_valid_reg;
    logic       out_valid_reg;
    logic       out_free;
    logic       advance;
    key_state_t st_reg;
    key_state_t st_next;
    res_t       res_next;
    res_t       res_reg;
    logic [7:0] key_reg;

    thkr_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    thkr_resolve u_resolve (
        .cfg     (cfg),
        .st      (st_reg),
        .evt     (evt_reg),
        .st_next (st_next),
        .res     (res_next)
    );

    assign out_free = !out_valid_reg || m_tready;
    assign advance  = in_valid_reg && out_free;
    assign s_tready = !in_valid_reg || out_free;

    always_comb
    begin
        evt_next.action         = action_t'(s_tuser);
        evt_next.now            = s_tdata[TIME_BITS-1:0];
        evt_next.other_pressed  = s_tdata[NOW_W];
        evt_next.other_released = s_tdata[NOW_W+1];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            evt_reg <= evt_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= KEY_STATE_RESET;
        end
        else if (advance)
        begin
            st_reg <= st_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            res_reg <= res_next;
            key_reg <= cfg.key_position;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {3'b000, res_reg.undecided, key_reg, res_reg.second_code,
                       res_reg.second_kind, res_reg.first_code, res_reg.first_kind};

    `THKR_ASSERT_NEXT(a_in_holds_on_stall, in_valid_reg && !out_free, in_valid_reg,
        "input register dropped an event while the result was stalled")
    `THKR_ASSERT_NEXT(a_undecided_matches, advance, res_reg.undecided == (st_reg.stage == ST_TAP),
        "undecided flag disagrees with the stored stage")
    `THKR_ASSERT_NEXT(a_second_needs_first, advance,
        !(res_reg.first_kind == K_NONE && res_reg.second_kind != K_NONE),
        "second action present without a first action")
    `THKR_ASSERT_NOW(a_ready_low_only_full, !s_tready,
        in_valid_reg && out_valid_reg && !m_tready,
        "input stalled while a stage was free")

endmodule
